// ===== design/aps_pkg.sv =====
package aps_pkg;

    // Largest number of results for one arc.
    localparam int MAX_POINTS = 64;
    // Number of CORDIC rotation steps for each sine/cosine evaluation.
    localparam int CORDIC_STEPS = 24;
    localparam int CS_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    // Width of the CORDIC vector components and of the unit vector.
    localparam int VEC_W = 34;

    localparam logic [15:0] RES_RESET = 16'd1229;
    localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;
    localparam logic [63:0] FULL_TURN_Q32 = 64'd26986075408;
    localparam logic signed [VEC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Bit position of the count step that means the count has reached 64.
    localparam logic [5:0] CNT_TOP = 6'd6;

    typedef struct packed {
        logic                    done;
        logic signed [VEC_W-1:0] cx;
        logic signed [VEC_W-1:0] sy;
    } t_cordic_out;

    // atan(2^-i) in Q2.30.
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:    v = 32'd843314856;
            5'd1:    v = 32'd497837829;
            5'd2:    v = 32'd263043836;
            5'd3:    v = 32'd133525158;
            5'd4:    v = 32'd67021686;
            5'd5:    v = 32'd33543515;
            5'd6:    v = 32'd16775850;
            5'd7:    v = 32'd8388437;
            5'd8:    v = 32'd4194282;
            5'd9:    v = 32'd2097149;
            5'd10:   v = 32'd1048575;
            5'd11:   v = 32'd524287;
            5'd12:   v = 32'd262143;
            5'd13:   v = 32'd131071;
            5'd14:   v = 32'd65535;
            5'd15:   v = 32'd32767;
            5'd16:   v = 32'd16383;
            5'd17:   v = 32'd8191;
            5'd18:   v = 32'd4095;
            5'd19:   v = 32'd2047;
            5'd20:   v = 32'd1023;
            5'd21:   v = 32'd512;
            5'd22:   v = 32'd256;
            5'd23:   v = 32'd128;
            5'd24:   v = 32'd64;
            5'd25:   v = 32'd32;
            5'd26:   v = 32'd16;
            5'd27:   v = 32'd8;
            5'd28:   v = 32'd4;
            5'd29:   v = 32'd2;
            5'd30:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [47:0] v);
        logic [31:0] r;
        if (v > 48'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -48'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== design/aps_ifs.sv =====
interface aps_arc_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_heading;
    logic signed [31:0] curvature;
    logic        [30:0] arc_length;

    modport source (output valid, start_x, start_y, start_heading, curvature, arc_length,
                    input ready);
    modport sink (input valid, start_x, start_y, start_heading, curvature, arc_length,
                  output ready);
endinterface

interface aps_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic        [5:0]  sample_index;
    logic               last_sample;

    modport source (output valid, point_x, point_y, sample_index, last_sample, input ready);
    modport sink (input valid, point_x, point_y, sample_index, last_sample, output ready);
endinterface

interface aps_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] angle_resolution;

    modport source (output valid, angle_resolution, input ready);
    modport sink (input valid, angle_resolution, output ready);
endinterface

// ===== design/aps_cordic.sv =====
module aps_cordic import aps_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [30:0]       i_z,
    input  logic [1:0]        i_quad,
    output t_cordic_out       o_res
);

    logic                    r_busy;
    logic [CS_W-1:0]         r_k;
    logic signed [VEC_W-1:0] r_x, r_y;
    logic signed [32:0]      r_z;
    logic [1:0]              r_q;
    logic                    r_done;
    logic signed [VEC_W-1:0] r_cx, r_sy;

    logic signed [VEC_W-1:0] n_x, n_y;
    logic signed [32:0]      n_z;
    logic signed [32:0]      angle;

    // One rotation step; the direction follows the sign of the residual angle.
    always_comb begin
        angle = $signed({1'b0, atan_q30(5'(r_k))});
        if (!r_z[32]) begin
            n_x = r_x - (r_y >>> r_k);
            n_y = r_y + (r_x >>> r_k);
            n_z = r_z - angle;
        end else begin
            n_x = r_x + (r_y >>> r_k);
            n_y = r_y - (r_x >>> r_k);
            n_z = r_z + angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_x    <= CORDIC_GAIN_Q30;
                r_y    <= '0;
                r_z    <= $signed({2'b00, i_z});
                r_q    <= i_quad;
            end else if (r_busy) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_k <= r_k + 1'b1;
                if (r_k == CS_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    unique case (r_q)
                        2'd0: begin r_cx <= n_x;  r_sy <= n_y;  end
                        2'd1: begin r_cx <= -n_y; r_sy <= n_x;  end
                        2'd2: begin r_cx <= -n_x; r_sy <= -n_y; end
                        default: begin r_cx <= n_y; r_sy <= -n_x; end
                    endcase
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.cx   = r_cx;
    assign o_res.sy   = r_sy;

endmodule

// ===== design/arc_point_sampler_core.sv =====
// Channel  Direction  Payload
// i_arc    in         start_x, start_y, start_heading, curvature, arc_length
// o_point  out        point_x, point_y, sample_index, last_sample
// i_cfg    in         angle_resolution (always ready)
//
// An arc's setup takes one multiply, up to seven count steps and two restoring divisions of
// 31 and 33 steps on the shared subtractor; each further point takes 30 phase reduction
// steps on the same subtractor and CORDIC_STEPS rotations in the CORDIC unit. A straight
// arc goes from idle straight to the output register with its start point.
// Reset is synchronous and active low; it clears the sequencer and the output valid flag and
// loads the default resolution. A stalled output only holds the sequencer when the next
// result is finished and the output register is still full.
module arc_point_sampler_core import aps_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    aps_arc_if.sink       i_arc,
    aps_point_if.source   o_point,
    aps_cfg_if.sink       i_cfg
);

    typedef enum logic [20:0] {
        S_IDLE   = 21'h000001,
        S_MULP   = 21'h000002,
        S_CNTLD  = 21'h000004,
        S_CNT    = 21'h000008,
        S_CHK    = 21'h000010,
        S_DIV    = 21'h000020,
        S_DIVEND = 21'h000040,
        S_PHC    = 21'h000080,
        S_STEP   = 21'h000100,
        S_MULL   = 21'h000200,
        S_PHL    = 21'h000400,
        S_REDLD  = 21'h000800,
        S_RED    = 21'h001000,
        S_FIX    = 21'h002000,
        S_Q1     = 21'h004000,
        S_Q0     = 21'h008000,
        S_CWAIT  = 21'h010000,
        S_MX     = 21'h020000,
        S_MY     = 21'h040000,
        S_ADD    = 21'h080000,
        S_EMIT   = 21'h100000
    } t_state;

    t_state r_state;

    // Latched arc and configuration.
    logic [15:0]        r_res;
    logic signed [31:0] r_sx, r_sy, r_head, r_crv;
    logic [30:0]        r_len;

    // Working state.
    logic [6:0]         r_n;
    logic [5:0]         r_i;
    logic [31:0]        r_step;
    logic [31:0]        r_l;
    logic signed [33:0] r_invc;
    logic signed [47:0] r_ctr_x, r_ctr_y;
    logic signed [37:0] r_offx;
    logic signed [63:0] r_phase;
    logic               r_neg;
    logic               r_center;
    logic               r_divinv;
    logic [63:0]        r_rem;
    logic [32:0]        r_dvd;
    logic [32:0]        r_quo;
    logic [5:0]         r_cnt;
    logic               r_quad;
    logic signed [67:0] r_prod;

    // Pending result and output register.
    logic [31:0]        r_px, r_py;
    logic [5:0]         r_pidx;
    logic               r_plast;
    logic               r_ov;
    logic [31:0]        r_ox, r_oy;
    logic [5:0]         r_oidx;
    logic               r_olast;

    logic [32:0]        crv_mag;
    logic signed [63:0] head_q32;
    logic signed [33:0] mul_a, mul_b;
    logic [63:0]        s_a, s_b, s_diff;
    logic               s_ge;
    logic               cordic_start;
    logic [30:0]        cordic_z;
    t_cordic_out        cordic_res;
    logic signed [37:0] off_y;
    logic signed [47:0] pt_x, pt_y;
    logic [6:0]         n_clamp;

    assign crv_mag  = r_crv[31] ? (33'd0 - {r_crv[31], r_crv}) : {1'b0, r_crv};
    assign head_q32 = $signed({{16{r_head[31]}}, r_head, 16'd0});
    assign off_y    = $signed(r_prod[67:30]);
    assign pt_x     = r_ctr_x + 48'(r_offx);
    assign pt_y     = r_ctr_y + 48'(off_y);
    assign n_clamp  = (r_n > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : r_n;

    // The one multiplier, registered; the state picks its operands.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MULP: begin
                mul_a = $signed({1'b0, crv_mag});
                mul_b = $signed({3'b000, r_len});
            end
            S_MULL: begin
                mul_a = $signed({2'b00, r_l});
                mul_b = 34'(r_crv);
            end
            S_MX: begin
                mul_a = r_invc;
                mul_b = cordic_res.cx;
            end
            S_MY: begin
                mul_a = r_invc;
                mul_b = cordic_res.sy;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // The shared compare-and-subtract unit: count, both divisions, the phase reduction and the quadrant steps.
    always_comb begin
        s_a = r_rem;
        s_b = '0;
        unique case (r_state)
            S_CNT: s_b = 64'(r_res) << (6'd20 + r_cnt);
            S_DIV: begin
                s_a = {r_rem[62:0], r_dvd[r_cnt]};
                s_b = r_divinv ? 64'(crv_mag) : 64'(r_n);
            end
            S_RED: s_b = FULL_TURN_Q32 << r_cnt;
            S_FIX: begin
                s_a = FULL_TURN_Q32;
                s_b = r_rem;
            end
            S_Q1:  s_b = HALF_PI_Q32 << 1;
            S_Q0:  s_b = HALF_PI_Q32;
            default: s_b = '0;
        endcase
        s_ge   = s_a >= s_b;
        s_diff = s_a - s_b;
    end

    // The remainder after the last quadrant step is below a quarter turn.
    assign cordic_start = (r_state == S_Q0);
    assign cordic_z     = s_ge ? s_diff[32:2] : r_rem[32:2];

    aps_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_z     (cordic_z),
        .i_quad  ({r_quad, s_ge}),
        .o_res   (cordic_res)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res   <= RES_RESET;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_res <= i_cfg.angle_resolution;
            end
            if (o_point.ready && r_state != S_EMIT) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_arc.valid) begin
                        r_sx   <= i_arc.start_x;
                        r_sy   <= i_arc.start_y;
                        r_head <= i_arc.start_heading;
                        r_crv  <= i_arc.curvature;
                        r_len  <= i_arc.arc_length;
                        if (i_arc.curvature == 32'sd0) begin
                            // A straight arc gives the start point alone.
                            r_px    <= i_arc.start_x;
                            r_py    <= i_arc.start_y;
                            r_pidx  <= '0;
                            r_plast <= 1'b1;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_MULP;
                        end
                    end
                end
                S_MULP: r_state <= S_CNTLD;
                S_CNTLD: begin
                    r_rem <= r_prod[63:0];
                    r_cnt <= CNT_TOP;
                    if (r_res == 16'd0) begin
                        r_n     <= 7'(MAX_POINTS);
                        r_state <= S_CHK;
                    end else begin
                        r_n     <= '0;
                        r_state <= S_CNT;
                    end
                end
                S_CNT: begin
                    // Long division of the swept angle by the resolution, one quotient bit
                    // a cycle; a set top bit means the count saturates.
                    if (s_ge && r_cnt == CNT_TOP) begin
                        r_n     <= 7'(MAX_POINTS);
                        r_state <= S_CHK;
                    end else begin
                        if (s_ge) begin
                            r_rem           <= s_diff;
                            r_n[r_cnt[2:0]] <= 1'b1;
                        end
                        if (r_cnt == 6'd0) begin
                            r_state <= S_CHK;
                        end else begin
                            r_cnt <= r_cnt - 1'b1;
                        end
                    end
                end
                S_CHK: begin
                    r_n <= n_clamp;
                    if (n_clamp <= 7'd1) begin
                        r_px    <= r_sx;
                        r_py    <= r_sy;
                        r_pidx  <= '0;
                        r_plast <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_rem    <= '0;
                        r_dvd    <= {2'b00, r_len};
                        r_cnt    <= 6'd30;
                        r_quo    <= '0;
                        r_divinv <= 1'b0;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem        <= s_ge ? s_diff : s_a;
                    r_quo[r_cnt] <= s_ge;
                    if (r_cnt == 6'd0) begin
                        r_state <= S_DIVEND;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DIVEND: begin
                    if (!r_divinv) begin
                        // Length step done; now 2^32 over the curvature magnitude.
                        r_step   <= r_quo[31:0];
                        r_rem    <= '0;
                        r_dvd    <= 33'h1_0000_0000;
                        r_cnt    <= 6'd32;
                        r_quo    <= '0;
                        r_divinv <= 1'b1;
                        r_state  <= S_DIV;
                    end else begin
                        r_invc  <= r_crv[31] ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
                        r_state <= S_PHC;
                    end
                end
                S_PHC: begin
                    // The center lies a quarter turn to the left of the heading.
                    r_phase  <= head_q32 + $signed(HALF_PI_Q32);
                    r_center <= 1'b1;
                    r_state  <= S_REDLD;
                end
                S_STEP: begin
                    r_i     <= r_i + 1'b1;
                    r_l     <= r_l + r_step;
                    r_state <= S_MULL;
                end
                S_MULL: r_state <= S_PHL;
                S_PHL: begin
                    r_phase  <= head_q32 - $signed(HALF_PI_Q32) + r_prod[63:0];
                    r_center <= 1'b0;
                    r_state  <= S_REDLD;
                end
                S_REDLD: begin
                    // Reduce the magnitude, then fold a negative phase back into one turn.
                    r_neg   <= r_phase[63];
                    r_rem   <= r_phase[63] ? 64'(-r_phase) : 64'(r_phase);
                    r_cnt   <= 6'd29;
                    r_state <= S_RED;
                end
                S_RED: begin
                    if (s_ge) begin
                        r_rem <= s_diff;
                    end
                    if (r_cnt == 6'd0) begin
                        r_state <= S_FIX;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_FIX: begin
                    if (r_neg && r_rem != 64'd0) begin
                        r_rem <= s_diff;
                    end
                    r_state <= S_Q1;
                end
                S_Q1: begin
                    if (s_ge) begin
                        r_rem <= s_diff;
                    end
                    r_quad  <= s_ge;
                    r_state <= S_Q0;
                end
                S_Q0: r_state <= S_CWAIT;
                S_CWAIT: begin
                    if (cordic_res.done) begin
                        r_state <= S_MX;
                    end
                end
                S_MX: r_state <= S_MY;
                S_MY: begin
                    r_offx  <= $signed(r_prod[67:30]);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (r_center) begin
                        r_ctr_x <= 48'(r_sx) + 48'(r_offx);
                        r_ctr_y <= 48'(r_sy) + 48'(off_y);
                        r_i     <= '0;
                        r_l     <= '0;
                        r_px    <= r_sx;
                        r_py    <= r_sy;
                        r_pidx  <= '0;
                        r_plast <= 1'b0;
                    end else begin
                        r_px    <= sat32(pt_x);
                        r_py    <= sat32(pt_y);
                        r_pidx  <= r_i;
                        r_plast <= (r_i == 6'(r_n - 7'd1));
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_ov || o_point.ready) begin
                        r_ov    <= 1'b1;
                        r_ox    <= r_px;
                        r_oy    <= r_py;
                        r_oidx  <= r_pidx;
                        r_olast <= r_plast;
                        r_state <= r_plast ? S_IDLE : S_STEP;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_arc.ready          = (r_state == S_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_point.valid        = r_ov;
    assign o_point.point_x      = r_ox;
    assign o_point.point_y      = r_oy;
    assign o_point.sample_index = r_oidx;
    assign o_point.last_sample  = r_olast;

endmodule

// ===== tb/sv/aps_tb_ifs.sv =====
// Testbench-side types. The block's own interfaces are used for the connection;
// this file only holds small shared helpers for the testbench.
package aps_tb_pkg;

    import aps_pkg::*;

    // One arc as the testbench builds and predicts it.
    typedef struct {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_heading;
        logic signed [31:0] curvature;
        logic        [30:0] arc_length;
    } t_arc;

    // One sampled point as the block returns it.
    typedef struct {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic        [5:0]  sample_index;
        logic               last_sample;
    } t_point;

endpackage

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import aps_pkg::*;
    import aps_tb_pkg::*;

    logic i_clk;
    logic i_rst_n;

    aps_arc_if   arc_ch ();
    aps_point_if point_ch ();
    aps_cfg_if   cfg_ch ();

    arc_point_sampler_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_arc   (arc_ch.sink),
        .o_point (point_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // 4 ns clock period.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Predictor state: the active resolution and the queue of points still owed.
    logic [15:0] resolution_now;
    t_point      points_owed[$];
    int          mismatch_count;
    bit          idle_enable;
    bit          sink_stall;

    // Step angles atan(2^-i) in Q2.30, built once from the alternating series.
    longint step_angle_q30[64];

    function automatic longint floor_shr(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-(v + 1)) >>> s) - 1;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic longint series_atan(int i);
        longint acc;
        longint term;
        int     e;
        acc = 0;
        if (i == 0) return longint'(HALF_PI_Q32) >>> 3;
        for (int k = 0; k < 64; k++) begin
            e = i * (2 * k + 1);
            if (e > 62) break;
            term = longint'((64'd1 << (62 - e)) / (2 * k + 1));
            acc += (k % 2 == 1) ? -term : term;
        end
        if (acc < 0) acc = 0;
        return acc >>> 32;
    endfunction

    // Cosine and sine of a Q32.32 phase, returned in Q2.30.
    task automatic polar_unit(input longint phase, output longint ux, output longint uy);
        longint half_pi;
        longint full_turn;
        longint r;
        longint quadrant;
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        half_pi = longint'(HALF_PI_Q32);
        full_turn = 4 * half_pi;
        r = phase % full_turn;
        if (r < 0) r += full_turn;
        quadrant = r / half_pi;
        z = (r - quadrant * half_pi) >>> 2;
        x = longint'(CORDIC_GAIN_Q30);
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 63; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= step_angle_q30[i];
            end else begin
                x += dx;
                y -= dy;
                z += step_angle_q30[i];
            end
        end
        case (quadrant % 4)
            0: begin ux = x;  uy = y;  end
            1: begin ux = -y; uy = x;  end
            2: begin ux = -x; uy = -y; end
            default: begin ux = y; uy = -x; end
        endcase
    endtask

    function automatic t_point make_point(longint px, longint py, int idx, bit last);
        t_point p;
        p.point_x = clamp32(px);
        p.point_y = clamp32(py);
        p.sample_index = idx[5:0];
        p.last_sample = last;
        return p;
    endfunction

    // Appends one point to the tail of the owed queue.
    function automatic void owe_point(t_point p);
        points_owed.insert(points_owed.size(), p);
    endfunction

    // Works out every point that one arc yields and appends them to the owed queue.
    task automatic predict_arc_points(input t_arc a);
        longint sx;
        longint sy;
        longint crv;
        longint len;
        longint prod;
        longint n;
        longint step_len;
        longint inv_crv;
        longint head_q32;
        longint ux;
        longint uy;
        longint center_x;
        longint center_y;
        sx = a.start_x;
        sy = a.start_y;
        crv = a.curvature;
        len = {33'd0, a.arc_length};
        if (crv == 0) begin
            owe_point(make_point(sx, sy, 0, 1'b1));
            return;
        end
        prod = (crv < 0 ? -crv : crv) * len;
        if (resolution_now == 0) begin
            n = MAX_POINTS;
        end else begin
            n = longint'(64'(prod) / (64'(resolution_now) << 20));
            if (n > MAX_POINTS) n = MAX_POINTS;
        end
        if (n <= 1) begin
            owe_point(make_point(sx, sy, 0, 1'b1));
            return;
        end
        step_len = len / n;
        inv_crv = 64'sd4294967296 / crv;
        head_q32 = longint'(a.start_heading) * 65536;
        polar_unit(head_q32 + longint'(HALF_PI_Q32), ux, uy);
        center_x = sx + floor_shr(inv_crv * ux, 30);
        center_y = sy + floor_shr(inv_crv * uy, 30);
        owe_point(make_point(sx, sy, 0, 1'b0));
        for (int i = 1; i < n; i++) begin
            polar_unit(head_q32 - longint'(HALF_PI_Q32) + longint'(i) * step_len * crv, ux, uy);
            owe_point(make_point(center_x + floor_shr(inv_crv * ux, 30),
                                 center_y + floor_shr(inv_crv * uy, 30),
                                 i, i + 1 == n));
        end
    endtask

    // Random idle decision: true about 18 times in a hundred when idling is enabled.
    function automatic bit idle_now();
        return idle_enable && ($urandom_range(99) < 18);
    endfunction

    // Sends one arc; the expectation is formed once the transfer is seen.
    task automatic send_arc(input t_arc a);
        @(negedge i_clk);
        while (idle_now()) @(negedge i_clk);
        arc_ch.valid <= 1'b1;
        arc_ch.start_x <= a.start_x;
        arc_ch.start_y <= a.start_y;
        arc_ch.start_heading <= a.start_heading;
        arc_ch.curvature <= a.curvature;
        arc_ch.arc_length <= a.arc_length;
        do @(posedge i_clk); while (!arc_ch.ready);
        predict_arc_points(a);
        @(negedge i_clk);
        arc_ch.valid <= 1'b0;
    endtask

    // Waits until every owed point has come, then lets the block settle.
    task automatic drain_points();
        while (points_owed.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    // Writes the resolution register while the block is idle.
    task automatic write_resolution(input logic [15:0] value);
        drain_points();
        cfg_ch.valid <= 1'b1;
        cfg_ch.angle_resolution <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        resolution_now = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_arc rand_arc(bit well_formed);
        t_arc a;
        a.start_x = $urandom();
        a.start_y = $urandom();
        a.start_heading = $urandom();
        a.curvature = $urandom();
        a.arc_length = 31'($urandom());
        if (well_formed) begin
            // Modest coordinates and radii so that points land in range and counts vary.
            a.start_x = $signed($urandom_range(2000000)) - 1000000;
            a.start_y = $signed($urandom_range(2000000)) - 1000000;
            a.start_heading = $signed($urandom_range(800000)) - 400000;
            a.curvature = $signed($urandom_range(1 << 17)) - (1 << 16);
            a.arc_length = 31'($urandom_range(1 << 22));
            if (a.curvature == 0) a.curvature = 1;
        end
        return a;
    endfunction

    function automatic t_arc arc_of(int sx, int sy, int hd, int crv, int len);
        t_arc a;
        a.start_x = sx;
        a.start_y = sy;
        a.start_heading = hd;
        a.curvature = crv;
        a.arc_length = len[30:0];
        return a;
    endfunction

    // Checker: each point transfer is compared with the oldest owed point.
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && point_ch.valid && point_ch.ready) begin
            if (points_owed.size() == 0) begin
                $error("point with no expectation: x=%0d y=%0d idx=%0d",
                       point_ch.point_x, point_ch.point_y, point_ch.sample_index);
                mismatch_count++;
            end else begin
                want = points_owed.pop_front();
                if (point_ch.point_x !== want.point_x) begin
                    $error("point_x expected %0d actual %0d", want.point_x, point_ch.point_x);
                    mismatch_count++;
                end
                if (point_ch.point_y !== want.point_y) begin
                    $error("point_y expected %0d actual %0d", want.point_y, point_ch.point_y);
                    mismatch_count++;
                end
                if (point_ch.sample_index !== want.sample_index) begin
                    $error("sample_index expected %0d actual %0d",
                           want.sample_index, point_ch.sample_index);
                    mismatch_count++;
                end
                if (point_ch.last_sample !== want.last_sample) begin
                    $error("last_sample expected %0d actual %0d",
                           want.last_sample, point_ch.last_sample);
                    mismatch_count++;
                end
            end
        end
    end

    // The receiver stalls at random, following the same idle switch.
    always @(negedge i_clk) begin
        sink_stall = idle_now();
        point_ch.ready <= !sink_stall;
    end

    // Extremes of every field, every special case, both signs of curvature.
    task automatic test_directed_arcs();
        send_arc(arc_of(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0));
        send_arc(arc_of(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 31'h7FFF_FFFF));
        send_arc(arc_of(100, -100, 0, 65536, 1000));
        send_arc(arc_of(0, 0, 0, 65536, 65536 * 3));
        send_arc(arc_of(0, 0, 102944, -65536, 65536 * 3));
        send_arc(arc_of(65536, 65536, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_arc(arc_of(-65536, 0, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF));
        send_arc(arc_of(0, 0, 0, 1, 31'h7FFF_FFFF));
        send_arc(arc_of(0, 0, -205887, -1, 31'h7FFF_FFFF));
        send_arc(arc_of(32'h7FFF_0000, 32'h7FFF_0000, 0, 6553, 65536 * 50));
        send_arc(arc_of(5000, 5000, 411775, 32768, 65536 * 20));
        send_arc(arc_of(0, 0, 0, 65536, 1));
    endtask

    task automatic test_resolution_settings();
        write_resolution(16'd0);
        send_arc(arc_of(0, 0, 0, 65536, 1));
        send_arc(arc_of(123, 456, 70000, -2000, 65536));
        write_resolution(16'hFFFF);
        send_arc(arc_of(0, 0, 0, 65536, 65536 * 100));
        send_arc(arc_of(0, 0, 0, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
        write_resolution(16'd1);
        send_arc(arc_of(0, 0, 0, 65536, 65536));
        write_resolution(16'd400);
    endtask

    // Mostly well-formed arcs with random content, some raw noise, some straight arcs; the resolution changes halfway.
    task automatic test_random_arcs(input int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (i == count / 2) write_resolution(16'($urandom_range(2000, 100)));
            if (pick < 75) begin
                send_arc(rand_arc(1'b1));
            end else if (pick < 90) begin
                send_arc(rand_arc(1'b0));
            end else begin
                t_arc a;
                a = rand_arc(1'b0);
                a.curvature = 0;
                send_arc(a);
            end
        end
    endtask

    initial begin
        mismatch_count = 0;
        idle_enable = 1'b0;
        resolution_now = RES_RESET;
        for (int i = 0; i < 64; i++) step_angle_q30[i] = series_atan(i);
        i_rst_n = 1'b0;
        arc_ch.valid = 1'b0;
        arc_ch.start_x = '0;
        arc_ch.start_y = '0;
        arc_ch.start_heading = '0;
        arc_ch.curvature = '0;
        arc_ch.arc_length = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.angle_resolution = '0;
        point_ch.ready = 1'b1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part runs without idling, which gives the long idle-free stretch.
        test_directed_arcs();
        idle_enable = 1'b1;
        test_resolution_settings();
        test_random_arcs(350);
        write_resolution(RES_RESET);
        send_arc(arc_of(0, 0, 0, 65536, 65536 * 2));
        drain_points();

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of every arc at full count with stalls.
    initial begin
        #60ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
